[hw/rtl/atce_pkg.sv]
// shared constants, types and helper functions for the text console engine
package atce_pkg;

    localparam int NUM_COLS    = 80;
    localparam int NUM_ROWS    = 25;
    localparam int PARAM_LIMIT = 16;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int CELLS       = NUM_ROWS * NUM_COLS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int PCNT_W      = $clog2(PARAM_LIMIT + 1);
    localparam logic [15:0] NUM_MAX = 16'hFFFF;

    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_AT    = 8'd64;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_B     = 8'd66;
    localparam logic [7:0] CH_C     = 8'd67;
    localparam logic [7:0] CH_D     = 8'd68;
    localparam logic [7:0] CH_H     = 8'd72;
    localparam logic [7:0] CH_J     = 8'd74;
    localparam logic [7:0] CH_LBRK  = 8'd91;
    localparam logic [7:0] CH_F     = 8'd102;
    localparam logic [7:0] CH_TILDE = 8'd126;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI
    } phase_t;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
        logic out_free;
    } stat_t;

    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col,
                                                     input logic [ROW_W-1:0] base);
        logic [ROW_W:0] s;
        s = {1'b0, row} + {1'b0, base};
        if (s >= (ROW_W+1)'(NUM_ROWS)) begin
            s = s - (ROW_W+1)'(NUM_ROWS);
        end
        return ADDR_W'(s) * ADDR_W'(NUM_COLS) + ADDR_W'(col);
    endfunction

    function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] n;
        n = 20'(v) * 20'd10 + 20'(d);
        return (n > 20'(NUM_MAX)) ? NUM_MAX : n[15:0];
    endfunction

endpackage

[hw/rtl/atce_ctrl.sv]
// sequencing state machine of the text console engine
module atce_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  atce_pkg::stat_t stat,
    output atce_pkg::cmd_t  cmd
);

    atce_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atce_pkg::ST_BOOT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            atce_pkg::ST_BOOT: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = atce_pkg::ST_IDLE;
                end
            end
            atce_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = atce_pkg::ST_EXEC;
                end
            end
            atce_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.need_sweep ? atce_pkg::ST_SWEEP : atce_pkg::ST_PUSH;
            end
            atce_pkg::ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = atce_pkg::ST_PUSH;
                end
            end
            atce_pkg::ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = atce_pkg::ST_IDLE;
                end
            end
            default: state_next = atce_pkg::ST_BOOT;
        endcase
    end

endmodule

[hw/rtl/atce_datapath.sv]
// cell store, cursor, escape parser and result register of the text console engine
module atce_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  atce_pkg::cmd_t       cmd,
    output atce_pkg::stat_t      stat,
    input  logic [1:0]           s_op,
    input  logic [7:0]           s_byte_in,
    input  logic [4:0]           s_read_row,
    input  logic [6:0]           s_read_col,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [4:0]           m_cursor_row,
    output logic [6:0]           m_cursor_col,
    output logic                 m_cell_written,
    output logic [4:0]           m_written_row,
    output logic [6:0]           m_written_col,
    output logic [7:0]           m_written_char,
    output logic                 m_scrolled,
    output logic                 m_present_frame,
    output logic                 m_display_held,
    output logic [7:0]           m_read_char,
    output logic [atce_pkg::ADDR_W-1:0] sweep_addr,
    output logic [atce_pkg::ADDR_W-1:0] sweep_end
);

    localparam int RW = atce_pkg::ROW_W;
    localparam int CW = atce_pkg::COL_W;
    localparam int AW = atce_pkg::ADDR_W;

    logic [7:0] mem [atce_pkg::CELLS];

    // latched item
    logic [1:0]    op_reg;
    logic [7:0]    ch_reg;
    logic [RW-1:0] rr_reg;
    logic [CW-1:0] rc_reg;

    // console state
    logic [RW-1:0] row_reg, row_next, base_reg, base_next;
    logic [CW-1:0] col_reg, col_next;
    atce_pkg::phase_t phase_reg, phase_next;
    logic [atce_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [1:0]    sep_reg, sep_next;
    logic [15:0]   n1_reg, n1_next, n2_reg, n2_next;
    logic          p1_reg, p1_next, p2_reg, p2_next;
    logic          hold_reg, hold_next;

    logic [AW-1:0] sw_reg, sw_end_reg;

    // pending result
    logic          wrote, rolled, present, wipe;
    logic [RW-1:0] wr;
    logic [CW-1:0] wc;
    logic [7:0]    wch;
    logic          res_wrote_reg, res_rolled_reg, res_present_reg;
    logic [RW-1:0] res_wr_reg;
    logic [CW-1:0] res_wc_reg;
    logic [7:0]    res_wch_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_ok_reg;
    logic          m_valid_reg;

    logic [15:0]   p0, q1, r_h, c_h;
    logic [16:0]   sum_r, sum_c;
    logic [RW:0]   rt;
    logic [CW:0]   ct;
    logic          rd_ok;
    logic [AW-1:0] wa, ra, row_start;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        phase_next = phase_reg;
        pcnt_next  = pcnt_reg;
        sep_next   = sep_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        hold_next  = hold_reg;
        wrote      = 1'b0;
        rolled     = 1'b0;
        present    = 1'b0;
        wipe       = 1'b0;
        wr         = '0;
        wc         = '0;
        wch        = '0;
        rt         = {1'b0, row_reg};
        ct         = {1'b0, col_reg};
        p0         = p1_reg ? n1_reg : 16'd1;
        q1         = (sep_reg >= 2'd1 && p2_reg) ? n2_reg : 16'd1;
        r_h        = (p0 == 16'd0) ? 16'd0 : p0 - 16'd1;
        c_h        = (q1 == 16'd0) ? 16'd0 : q1 - 16'd1;
        sum_r      = 17'(row_reg) + 17'(p0);
        sum_c      = 17'(col_reg) + 17'(p0);
        case (op_reg)
            atce_pkg::OP_CLEAR: begin
                hold_next = 1'b0;
                wipe      = 1'b1;
                row_next  = '0;
                col_next  = '0;
                base_next = '0;
            end
            atce_pkg::OP_FEED: begin
                if (phase_reg == atce_pkg::PH_ESC) begin
                    phase_next = (ch_reg == atce_pkg::CH_LBRK) ? atce_pkg::PH_CSI
                                                               : atce_pkg::PH_TEXT;
                    pcnt_next  = '0;
                    sep_next   = '0;
                    n1_next    = '0;
                    n2_next    = '0;
                    p1_next    = 1'b0;
                    p2_next    = 1'b0;
                end else if (phase_reg == atce_pkg::PH_CSI) begin
                    if (ch_reg >= atce_pkg::CH_AT && ch_reg <= atce_pkg::CH_TILDE) begin
                        phase_next = atce_pkg::PH_TEXT;
                        if (ch_reg == atce_pkg::CH_J) begin
                            if (p1_reg && n1_reg == 16'd2) begin
                                wipe      = 1'b1;
                                hold_next = 1'b1;
                                row_next  = '0;
                                col_next  = '0;
                                base_next = '0;
                            end
                        end else if (ch_reg == atce_pkg::CH_H || ch_reg == atce_pkg::CH_F) begin
                            row_next = (r_h >= 16'(atce_pkg::NUM_ROWS))
                                     ? RW'(atce_pkg::NUM_ROWS - 1) : r_h[RW-1:0];
                            col_next = (c_h >= 16'(atce_pkg::NUM_COLS))
                                     ? CW'(atce_pkg::NUM_COLS - 1) : c_h[CW-1:0];
                            if (hold_reg && (row_next != '0 || col_next != '0)) begin
                                hold_next = 1'b0;
                                present   = 1'b1;
                            end
                        end else if (ch_reg == atce_pkg::CH_A) begin
                            row_next = (16'(row_reg) > p0) ? row_reg - p0[RW-1:0] : '0;
                        end else if (ch_reg == atce_pkg::CH_B) begin
                            row_next = (sum_r < 17'(atce_pkg::NUM_ROWS))
                                     ? sum_r[RW-1:0] : RW'(atce_pkg::NUM_ROWS - 1);
                        end else if (ch_reg == atce_pkg::CH_C) begin
                            col_next = (sum_c < 17'(atce_pkg::NUM_COLS))
                                     ? sum_c[CW-1:0] : CW'(atce_pkg::NUM_COLS - 1);
                        end else if (ch_reg == atce_pkg::CH_D) begin
                            col_next = (16'(col_reg) > p0) ? col_reg - p0[CW-1:0] : '0;
                        end
                    end else if (pcnt_reg < atce_pkg::PCNT_W'(atce_pkg::PARAM_LIMIT)) begin
                        pcnt_next = pcnt_reg + 1'b1;
                        if (ch_reg == atce_pkg::CH_SEMI) begin
                            if (sep_reg < 2'd2) begin
                                sep_next = sep_reg + 2'd1;
                            end
                        end else if (ch_reg >= atce_pkg::CH_ZERO &&
                                     ch_reg <= atce_pkg::CH_NINE) begin
                            if (sep_reg == 2'd0) begin
                                n1_next = atce_pkg::add_digit(n1_reg, ch_reg[3:0]);
                                p1_next = 1'b1;
                            end else if (sep_reg == 2'd1) begin
                                n2_next = atce_pkg::add_digit(n2_reg, ch_reg[3:0]);
                                p2_next = 1'b1;
                            end
                        end
                    end
                end else if (ch_reg == atce_pkg::CH_ESC) begin
                    phase_next = atce_pkg::PH_ESC;
                end else if (ch_reg == atce_pkg::CH_CR) begin
                    col_next = '0;
                end else begin
                    if (ch_reg == atce_pkg::CH_LF) begin
                        ct = '0;
                        rt = rt + 1'b1;
                    end else if (ch_reg == atce_pkg::CH_BS) begin
                        if (ct != '0) begin
                            ct = ct - 1'b1;
                        end
                        wrote = 1'b1;
                        wr    = row_reg;
                        wc    = ct[CW-1:0];
                        wch   = atce_pkg::CH_SPACE;
                    end else begin
                        wrote = 1'b1;
                        wr    = row_reg;
                        wc    = col_reg;
                        wch   = ch_reg;
                        ct    = ct + 1'b1;
                    end
                    if (ct >= (CW+1)'(atce_pkg::NUM_COLS)) begin
                        ct = '0;
                        rt = rt + 1'b1;
                    end
                    if (rt >= (RW+1)'(atce_pkg::NUM_ROWS)) begin
                        rolled    = 1'b1;
                        rt        = (RW+1)'(atce_pkg::NUM_ROWS - 1);
                        base_next = (base_reg == RW'(atce_pkg::NUM_ROWS - 1))
                                  ? '0 : base_reg + 1'b1;
                    end
                    row_next = rt[RW-1:0];
                    col_next = ct[CW-1:0];
                end
            end
            default: ;
        endcase
    end

    assign rd_ok     = (op_reg == atce_pkg::OP_READ) &&
                       (rr_reg < RW'(atce_pkg::NUM_ROWS)) && (rc_reg < CW'(atce_pkg::NUM_COLS));
    assign wa        = atce_pkg::phys_addr(wr, wc, base_reg);
    assign ra        = atce_pkg::phys_addr(rr_reg, rc_reg, base_reg);
    assign row_start = AW'(base_reg) * AW'(atce_pkg::NUM_COLS);

    assign mem_we = cmd.sweep || (cmd.exec && wrote);
    assign mem_wa = cmd.sweep ? sw_reg : wa;
    assign mem_wd = cmd.sweep ? atce_pkg::CH_SPACE : wch;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.exec && rd_ok) begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_op;
            ch_reg <= s_byte_in;
            rr_reg <= s_read_row;
            rc_reg <= s_read_col;
        end
        if (cmd.exec) begin
            res_wrote_reg   <= wrote;
            res_rolled_reg  <= rolled;
            res_present_reg <= present;
            res_wr_reg      <= wr;
            res_wc_reg      <= wc;
            res_wch_reg     <= wch;
        end
        if (cmd.push) begin
            m_cursor_row    <= row_reg;
            m_cursor_col    <= col_reg;
            m_cell_written  <= res_wrote_reg;
            m_written_row   <= res_wr_reg;
            m_written_col   <= res_wc_reg;
            m_written_char  <= res_wch_reg;
            m_scrolled      <= res_rolled_reg;
            m_present_frame <= res_present_reg;
            m_display_held  <= hold_reg;
            m_read_char     <= rd_ok_reg ? rd_data_reg : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            base_reg    <= '0;
            phase_reg   <= atce_pkg::PH_TEXT;
            pcnt_reg    <= '0;
            sep_reg     <= '0;
            n1_reg      <= '0;
            n2_reg      <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            hold_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
            sw_reg      <= '0;
            sw_end_reg  <= AW'(atce_pkg::CELLS - 1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                base_reg  <= base_next;
                phase_reg <= phase_next;
                pcnt_reg  <= pcnt_next;
                sep_reg   <= sep_next;
                n1_reg    <= n1_next;
                n2_reg    <= n2_next;
                p1_reg    <= p1_next;
                p2_reg    <= p2_next;
                hold_reg  <= hold_next;
                rd_ok_reg <= rd_ok;
                if (wipe) begin
                    sw_reg     <= '0;
                    sw_end_reg <= AW'(atce_pkg::CELLS - 1);
                end else if (rolled) begin
                    // blank the old top row, now the bottom line
                    sw_reg     <= row_start;
                    sw_end_reg <= row_start + AW'(atce_pkg::NUM_COLS - 1);
                end
            end else if (cmd.sweep && sw_reg != sw_end_reg) begin
                sw_reg <= sw_reg + 1'b1;
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign stat.need_sweep = wipe || rolled;
    assign stat.sweep_last = (sw_reg == sw_end_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign sweep_addr      = sw_reg;
    assign sweep_end       = sw_end_reg;

endmodule

[hw/rtl/ansi_text_console_engine_unit.sv]
// top level of the text console engine: controller plus datapath
//
// usage
// - input channel s_*: one item per transfer; s_op selects feed byte (s_byte_in),
//   read cell (s_read_row, s_read_col) or clear screen and cursor
// - result channel m_*: exactly one result transfer per input item, in order
// - a plain item goes from input transfer to m_valid through the execute state
//   (execute with memory access) and the push state (load result register)
// - no new item is taken until the last one's result is loaded; each item passes
//   through the idle, execute and push states of the controller
// - a scroll adds a sweep that blanks one row of NUM_COLS cells (80)
// - a clear item or ESC [ 2 J adds a full store sweep of NUM_ROWS*NUM_COLS
//   cells (2000)
// - after reset the store is blanked by the same full store sweep, with
//   s_ready low throughout
// - when the receiver stalls the result stays in the output register and the
//   block holds the next item before its result load until m_ready frees it
module ansi_text_console_engine_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_byte_in,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_cursor_row,
    output logic [6:0] m_cursor_col,
    output logic       m_cell_written,
    output logic [4:0] m_written_row,
    output logic [6:0] m_written_col,
    output logic [7:0] m_written_char,
    output logic       m_scrolled,
    output logic       m_present_frame,
    output logic       m_display_held,
    output logic [7:0] m_read_char
);

    atce_pkg::cmd_t  cmd;
    atce_pkg::stat_t stat;
    logic [atce_pkg::ADDR_W-1:0] sweep_addr, sweep_end;

    // sequencing
    atce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // store, cursor, parser, result register
    atce_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_op            (s_op),
        .s_byte_in       (s_byte_in),
        .s_read_row      (s_read_row),
        .s_read_col      (s_read_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_col    (m_cursor_col),
        .m_cell_written  (m_cell_written),
        .m_written_row   (m_written_row),
        .m_written_col   (m_written_col),
        .m_written_char  (m_written_char),
        .m_scrolled      (m_scrolled),
        .m_present_frame (m_present_frame),
        .m_display_held  (m_display_held),
        .m_read_char     (m_read_char),
        .sweep_addr      (sweep_addr),
        .sweep_end       (sweep_end)
    );

    // result register is only loaded when it is free
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> stat.out_free)
        else $error("result loaded over an untaken transfer");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in flight");

    // blank sweep never runs past its end address
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> (sweep_addr <= sweep_end))
        else $error("blank sweep past end");

    // an accept is followed by execution of that item
    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.exec)
        else $error("accepted item not executed");

endmodule
